// ----- rtl/core/sbrm_pkg.sv -----
// Shared constants, register codes and types for the sensor bar run midpoint block.
// No dependencies.

package sbrm_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int MAX_RESULTS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int WORD_W     = 16;
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int HALF_W     = 5;
  localparam int Y_W        = 8;

  localparam int MASK_W = MAX_SENSORS;
  localparam int IDX_W  = $clog2(MAX_SENSORS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_COUNT = 2'd0,
    REG_ACTIVE_LEVEL = 2'd1,
    REG_X_COORD      = 2'd2,
    REG_Z_COORD      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]          sensor_count;
    logic                      active_level;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] z_coord;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ----- rtl/core/sbrm_front.sv -----
// Front end: turns a raw sensor word into a mask of detected sensors.
// Depends on sbrm_pkg.

module sbrm_front (
  input  sbrm_pkg::cfg_t                  cfg_i,
  input  logic [sbrm_pkg::WORD_W-1:0]     sensor_word_i,
  output logic [sbrm_pkg::MASK_W-1:0]     mask_o,
  output logic                            has_run_o
);

  logic [sbrm_pkg::MASK_W-1:0] bits_w;
  logic [sbrm_pkg::CNT_W:0]    count_raw_w;
  logic [sbrm_pkg::CNT_W:0]    count_eff_w;

  // sensors past the word width read as zero
  for (genvar g = 0; g < sbrm_pkg::MASK_W; g++) begin : g_bits
    if (g < sbrm_pkg::WORD_W) begin : g_in
      assign bits_w[g] = sensor_word_i[g];
    end else begin : g_pad
      assign bits_w[g] = 1'b0;
    end
  end

  assign count_raw_w = {1'b0, cfg_i.sensor_count};
  assign count_eff_w = (int'(count_raw_w) > sbrm_pkg::MAX_SENSORS)
                       ? (sbrm_pkg::CNT_W + 1)'(sbrm_pkg::MAX_SENSORS) : count_raw_w;

  always_comb begin
    for (int i = 0; i < sbrm_pkg::MASK_W; i++) begin
      mask_o[i] = (i < int'(count_eff_w)) && (bits_w[i] == cfg_i.active_level);
    end
  end

  assign has_run_o = |mask_o;

endmodule

// ----- rtl/core/sbrm_queue.sv -----
// Short register queue of detection masks between front and back end.
// Depends on sbrm_pkg.

module sbrm_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [sbrm_pkg::MASK_W-1:0]  push_data_i,
  input  logic                         pop_i,
  output logic [sbrm_pkg::MASK_W-1:0]  pop_data_o,
  output sbrm_pkg::q_status_t          status_o
);

  localparam int PTR_W = (sbrm_pkg::QUEUE_DEPTH > 1) ? $clog2(sbrm_pkg::QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(sbrm_pkg::QUEUE_DEPTH + 1);

  logic [sbrm_pkg::MASK_W-1:0] mem_q [sbrm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(sbrm_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign status_o.full      = (level_q == LVL_W'(sbrm_pkg::QUEUE_DEPTH));
  assign status_o.not_empty = (level_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.not_empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q;
    if (do_push && !do_pop) begin
      level_d = level_q + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/sbrm_back.sv -----
// Back end: walks a detection mask one run per cycle unless the output stalls,
// and registers each result. Depends on sbrm_pkg.

module sbrm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbrm_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  logic [sbrm_pkg::MASK_W-1:0]         q_data_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbrm_pkg::HALF_W-1:0]         midpoint_half_o,
  output logic signed [sbrm_pkg::Y_W-1:0]     y_position_o,
  output logic signed [sbrm_pkg::COORD_W-1:0] x_out_o,
  output logic signed [sbrm_pkg::COORD_W-1:0] z_out_o,
  output logic                                last_run_o
);

  localparam int EXT_W = sbrm_pkg::MASK_W + 1;
  localparam int HW    = sbrm_pkg::IDX_W + 1;
  localparam int YF_W  = HW + 4;

  logic                        busy_q, busy_d;
  logic [sbrm_pkg::MASK_W-1:0] mask_q, mask_d;
  logic [sbrm_pkg::RES_W-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;

  logic [sbrm_pkg::HALF_W-1:0]         midpoint_half_q;
  logic signed [sbrm_pkg::Y_W-1:0]     y_position_q;
  logic signed [sbrm_pkg::COORD_W-1:0] x_out_q, z_out_q;
  logic                                last_run_q;

  logic [EXT_W-1:0]             ext_w, lowbit_w, sum_w;
  logic [sbrm_pkg::MASK_W-1:0]  rem_w;
  logic [sbrm_pkg::IDX_W-1:0]   first_w, end_w;
  logic [HW-1:0]                half_w;
  logic signed [YF_W-1:0]       y_full_w;
  logic [sbrm_pkg::HALF_W-1:0]  mid_sat_w;
  logic signed [sbrm_pkg::Y_W-1:0] y_sat_w;
  logic                         adv_w, last_w;

  // index of lowest set bit
  function automatic logic [sbrm_pkg::IDX_W-1:0] low_index(input logic [EXT_W-1:0] v);
    logic [sbrm_pkg::IDX_W-1:0] r;
    r = '0;
    for (int i = EXT_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = sbrm_pkg::IDX_W'(i);
      end
    end
    return r;
  endfunction

  // adding the lowest set bit ripples through the lowest run and lands just above it
  assign ext_w    = {1'b0, mask_q};
  assign lowbit_w = ext_w & (~ext_w + EXT_W'(1));
  assign sum_w    = ext_w + lowbit_w;
  assign rem_w    = ext_w[sbrm_pkg::MASK_W-1:0] & sum_w[sbrm_pkg::MASK_W-1:0];
  assign first_w  = low_index(ext_w);
  assign end_w    = low_index(sum_w);
  assign half_w   = HW'(first_w) + HW'(end_w) - HW'(1);

  assign y_full_w = $signed((YF_W'(half_w) << 2) + YF_W'(half_w)) - $signed(YF_W'(75));

  always_comb begin
    if (int'(half_w) > (2 ** sbrm_pkg::HALF_W) - 1) begin
      mid_sat_w = '1;
    end else begin
      mid_sat_w = sbrm_pkg::HALF_W'(half_w);
    end
    if (y_full_w > $signed(YF_W'(127))) begin
      y_sat_w = sbrm_pkg::Y_W'(127);
    end else if (y_full_w < -$signed(YF_W'(128))) begin
      y_sat_w = -sbrm_pkg::Y_W'(128);
    end else begin
      y_sat_w = sbrm_pkg::Y_W'(y_full_w);
    end
  end

  assign adv_w  = busy_q && (!out_valid_q || out_ready_i);
  assign last_w = (rem_w == '0) || (cnt_q == sbrm_pkg::RES_W'(sbrm_pkg::MAX_RESULTS - 1));
  assign pop_o  = q_valid_i && (!busy_q || (adv_w && last_w));

  always_comb begin
    busy_d      = busy_q;
    mask_d      = mask_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (adv_w) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      mask_d = q_data_i;
      cnt_d  = '0;
    end else if (adv_w) begin
      busy_d = !last_w;
      mask_d = rem_w;
      cnt_d  = cnt_q + sbrm_pkg::RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      mask_q      <= mask_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      midpoint_half_q <= mid_sat_w;
      y_position_q    <= y_sat_w;
      x_out_q         <= cfg_i.x_coord;
      z_out_q         <= cfg_i.z_coord;
      last_run_q      <= last_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign midpoint_half_o = midpoint_half_q;
  assign y_position_o    = y_position_q;
  assign x_out_o         = x_out_q;
  assign z_out_o         = z_out_q;
  assign last_run_o      = last_run_q;

  a_busy_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (mask_q != '0))
    else $error("busy with an empty mask");

  a_y_matches_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((sbrm_pkg::MAX_SENSORS > 16) ||
                     (int'(y_position_q) == 5 * int'(midpoint_half_q) - 75)))
    else $error("y position does not follow midpoint");

  a_walk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_w && !last_w) |=> (busy_q && (cnt_q == $past(cnt_q) + sbrm_pkg::RES_W'(1))))
    else $error("run walk stopped early");

  a_last_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_w && last_w && !q_valid_i) |=> !busy_q)
    else $error("busy after last run");

endmodule

// ----- rtl/core/sensor_bar_run_midpoints.sv -----
// Top level of the sensor bar run midpoint block: config registers, front end,
// mask queue and run walker. Depends on sbrm_pkg, sbrm_front, sbrm_queue, sbrm_back.
//
//   port group     handshake              payload
//   -------------  ---------------------  ----------------------------------------------
//   config write   cfg_we_i               cfg_idx_i, cfg_data_i
//   sensor in      in_valid_i/in_ready_o  sensor_word_i
//   result out     out_valid_o/out_ready_i midpoint_half_o, y_position_o, x_out_o,
//                                         z_out_o, last_run_o
//
// A word is taken whenever the two-entry mask queue has room.
// The run walker emits one result per cycle while it may advance, so a word with k runs
// (k up to 8) gives k results in turn; words without any run cost nothing there.
// Results sit in an output register; the walker keeps going while it is empty
// or being taken, and the queue keeps accepting words while the output stalls, until it is full.
// Reset clears config to its defaults (16 sensors, active low, x = z = 0) and
// empties queue and walker; there is no clearing pass.

module sensor_bar_run_midpoints (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sbrm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sbrm_pkg::WORD_W-1:0]         sensor_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbrm_pkg::HALF_W-1:0]         midpoint_half_o,
  output logic signed [sbrm_pkg::Y_W-1:0]     y_position_o,
  output logic signed [sbrm_pkg::COORD_W-1:0] x_out_o,
  output logic signed [sbrm_pkg::COORD_W-1:0] z_out_o,
  output logic                                last_run_o
);

  sbrm_pkg::cfg_t              cfg_q, cfg_d;
  sbrm_pkg::q_status_t         q_status;
  logic [sbrm_pkg::MASK_W-1:0] front_mask;
  logic [sbrm_pkg::MASK_W-1:0] q_head;
  logic                        front_has_run;
  logic                        push;
  logic                        pop;

  // Config registers; every index of the port names a register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sbrm_pkg::cfg_reg_e'(cfg_idx_i))
        sbrm_pkg::REG_SENSOR_COUNT: cfg_d.sensor_count = cfg_data_i[sbrm_pkg::CNT_W-1:0];
        sbrm_pkg::REG_ACTIVE_LEVEL: cfg_d.active_level = cfg_data_i[0];
        sbrm_pkg::REG_X_COORD:      cfg_d.x_coord      = $signed(cfg_data_i[sbrm_pkg::COORD_W-1:0]);
        sbrm_pkg::REG_Z_COORD:      cfg_d.z_coord      = $signed(cfg_data_i[sbrm_pkg::COORD_W-1:0]);
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_count <= sbrm_pkg::CNT_W'(16);
      cfg_q.active_level <= 1'b0;
      cfg_q.x_coord      <= '0;
      cfg_q.z_coord      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end classifies the word; an item with no run never enters the queue.
  sbrm_front u_front (
    .cfg_i         (cfg_q),
    .sensor_word_i (sensor_word_i),
    .mask_o        (front_mask),
    .has_run_o     (front_has_run)
  );

  assign in_ready_o = !q_status.full;
  assign push       = in_valid_i && in_ready_o && front_has_run;

  sbrm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_mask),
    .pop_i       (pop),
    .pop_data_o  (q_head),
    .status_o    (q_status)
  );

  // Back end walks runs low to high and owns the output register.
  sbrm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_status.not_empty),
    .q_data_i        (q_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .midpoint_half_o (midpoint_half_o),
    .y_position_o    (y_position_o),
    .x_out_o         (x_out_o),
    .z_out_o         (z_out_o),
    .last_run_o      (last_run_o)
  );

endmodule

// ----- verif/sensor_bar_run_midpoints_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sensor_bar_run_midpoints: directed and random sensor words
// under several register settings, results checked against a run-midpoint predictor.
// Depends on sbrm_pkg and the RTL of sensor_bar_run_midpoints.

module sensor_bar_run_midpoints_tb;

  localparam int HALF_CYCLE     = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int MAX_IDLE       = 5;
  // Settle time before a register write, after the last pending result has been seen;
  // run-free words never enter the queue.
  localparam int SETTLE_CYCLES  = 16;
  // Output hold-off long enough to back up the queue and stall the input.
  localparam int HOLD_CYCLES    = 80;
  // Longest legal quiet stretch is the hold-off plus a settle pause; keep a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int WORDS_PER_PHASE = 56;

  // One result of the block, field by field.
  typedef struct {
    logic [sbrm_pkg::HALF_W-1:0]         half;
    logic signed [sbrm_pkg::Y_W-1:0]     y;
    logic signed [sbrm_pkg::COORD_W-1:0] x;
    logic signed [sbrm_pkg::COORD_W-1:0] z;
    logic                                last;
  } run_result_t;

  // Predicts the runs of each accepted word and checks results in order.
  class run_scoreboard;
    sbrm_pkg::cfg_t cfg;
    run_result_t    expected_runs[$];
    int             errors;

    function new();
      cfg.sensor_count = sbrm_pkg::CNT_W'(16);
      cfg.active_level = 1'b0;
      cfg.x_coord      = '0;
      cfg.z_coord      = '0;
      errors           = 0;
    endfunction

    function void set_reg(sbrm_pkg::cfg_reg_e idx, logic [sbrm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sbrm_pkg::REG_SENSOR_COUNT: cfg.sensor_count = data[sbrm_pkg::CNT_W-1:0];
        sbrm_pkg::REG_ACTIVE_LEVEL: cfg.active_level = data[0];
        sbrm_pkg::REG_X_COORD:      cfg.x_coord      = data;
        sbrm_pkg::REG_Z_COORD:      cfg.z_coord      = data;
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    // Walk sensors 0..n, the position n acting as the undetected end pad.
    function void note_word(logic [sbrm_pkg::WORD_W-1:0] w);
      int          n;
      int          i;
      int          first;
      int          y;
      bit          in_run;
      bit          det;
      logic        sensor_bit;
      int          halves[$];
      run_result_t e;
      n = cfg.sensor_count;
      if (n > sbrm_pkg::MAX_SENSORS) n = sbrm_pkg::MAX_SENSORS;
      in_run = 1'b0;
      first  = 0;
      for (i = 0; i <= n; i++) begin
        det = 1'b0;
        if (i < n) begin
          sensor_bit = (i < sbrm_pkg::WORD_W) ? w[i] : 1'b0;
          det = (sensor_bit == cfg.active_level);
        end
        if (det && !in_run) begin
          in_run = 1'b1;
          first  = i;
        end else if (!det && in_run) begin
          in_run = 1'b0;
          if (halves.size() < sbrm_pkg::MAX_RESULTS) halves.insert(halves.size(), first + i - 1);
        end
      end
      foreach (halves[r]) begin
        y = 5 * halves[r] - 75;
        if (y > 127) y = 127;
        if (y < -128) y = -128;
        e.half = (halves[r] > (1 << sbrm_pkg::HALF_W) - 1)
                 ? sbrm_pkg::HALF_W'((1 << sbrm_pkg::HALF_W) - 1)
                 : sbrm_pkg::HALF_W'(halves[r]);
        e.y    = y[sbrm_pkg::Y_W-1:0];
        e.x    = cfg.x_coord;
        e.z    = cfg.z_coord;
        e.last = (r == halves.size() - 1);
        expected_runs.insert(expected_runs.size(), e);
      end
    endfunction

    task check_result(run_result_t got);
      run_result_t want;
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: half=%0d y=%0d",
                                  got.half, got.y));
        return;
      end
      want = expected_runs.pop_front();
      if (got.half !== want.half)
        report_mismatch($sformatf("midpoint_half %0d, want %0d", got.half, want.half));
      if (got.y !== want.y)
        report_mismatch($sformatf("y_position %0d, want %0d", got.y, want.y));
      if (got.x !== want.x)
        report_mismatch($sformatf("x_out %0d, want %0d", got.x, want.x));
      if (got.z !== want.z)
        report_mismatch($sformatf("z_out %0d, want %0d", got.z, want.z));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_run %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [sbrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [sbrm_pkg::CFG_DATA_W-1:0]     cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic [sbrm_pkg::WORD_W-1:0]         sensor_word_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [sbrm_pkg::HALF_W-1:0]         midpoint_half_o;
  logic signed [sbrm_pkg::Y_W-1:0]     y_position_o;
  logic signed [sbrm_pkg::COORD_W-1:0] x_out_o;
  logic signed [sbrm_pkg::COORD_W-1:0] z_out_o;
  logic                                last_run_o;

  run_scoreboard sb;
  bit            idle_on;   // random gaps on both sides when set
  bit            hold_req;  // one long output hold-off, taken by the receiver
  int            quiet_cycles;

  sensor_bar_run_midpoints dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sensor_word_i  (sensor_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .midpoint_half_o(midpoint_half_o),
    .y_position_o   (y_position_o),
    .x_out_o        (x_out_o),
    .z_out_o        (z_out_o),
    .last_run_o     (last_run_o)
  );

  initial clk_i = 1'b0;
  always #HALF_CYCLE clk_i = ~clk_i;

  // All inputs known from time zero.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sensor_word_i = '0;
    out_ready_i   = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    sb            = new();
  end

  // Watchdog: any handshake resets the count; a long silence means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Result side. Reads at the edge see pre-edge values, i.e. the item just taken.
  // Ready is only dropped when a stall is drawn, so it never toggles within a step.
  initial begin : receiver
    int          stall;
    run_result_t got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.half = midpoint_half_o;
      got.y    = y_position_o;
      got.x    = x_out_o;
      got.z    = z_out_o;
      got.last = last_run_o;
      sb.check_result(got);
    end
  end

  // Offer one word; valid stays up across back-to-back items with no gap.
  task automatic send_word(input logic [sbrm_pkg::WORD_W-1:0] w);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sensor_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  // Stop offering, wait for every pending result, then pause for the settle time.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input sbrm_pkg::cfg_reg_e idx,
                           input logic [sbrm_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic write_config(input logic [sbrm_pkg::CFG_DATA_W-1:0] count,
                              input logic [sbrm_pkg::CFG_DATA_W-1:0] level,
                              input logic [sbrm_pkg::CFG_DATA_W-1:0] x,
                              input logic [sbrm_pkg::CFG_DATA_W-1:0] z);
    write_reg(sbrm_pkg::REG_SENSOR_COUNT, count);
    write_reg(sbrm_pkg::REG_ACTIVE_LEVEL, level);
    write_reg(sbrm_pkg::REG_X_COORD, x);
    write_reg(sbrm_pkg::REG_Z_COORD, z);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of dense, sparse, fully random and near-alternating patterns, so both
  // long runs and many short runs show up for either active level.
  function automatic logic [sbrm_pkg::WORD_W-1:0] random_word();
    logic [sbrm_pkg::WORD_W-1:0] w;
    case ($urandom_range(0, 3))
      0: w = sbrm_pkg::WORD_W'($urandom);
      1: w = sbrm_pkg::WORD_W'($urandom & $urandom);
      2: w = sbrm_pkg::WORD_W'($urandom | $urandom);
      default: begin
        w = ($urandom_range(0, 1) != 0) ? 16'hAAAA : 16'h5555;
        w[$urandom_range(0, sbrm_pkg::WORD_W - 1)] ^= 1'b1;
      end
    endcase
    return w;
  endfunction

  // Upper data bits are random too; the block keeps only the register's width.
  task automatic random_config();
    logic [sbrm_pkg::CFG_DATA_W-1:0] count;
    logic [sbrm_pkg::CFG_DATA_W-1:0] level;
    count = sbrm_pkg::CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0:       count[sbrm_pkg::CNT_W-1:0] = sbrm_pkg::CNT_W'(sbrm_pkg::MAX_SENSORS);
      1:       count[sbrm_pkg::CNT_W-1:0] =
                 sbrm_pkg::CNT_W'($urandom_range(sbrm_pkg::MAX_SENSORS + 1, 31));
      default: count[sbrm_pkg::CNT_W-1:0] =
                 sbrm_pkg::CNT_W'($urandom_range(1, sbrm_pkg::MAX_SENSORS));
    endcase
    level = sbrm_pkg::CFG_DATA_W'($urandom);
    write_config(count, level, sbrm_pkg::CFG_DATA_W'($urandom),
                 sbrm_pkg::CFG_DATA_W'($urandom));
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 16 sensors, active low, coordinates zero.
    send_word(16'hFFFF);  // nothing detected
    send_word(16'h0000);  // one run over the whole bar
    send_word(16'hAAAA);  // eight runs on even sensors
    send_word(16'h5555);  // eight runs on odd sensors, top midpoint
    send_word(16'hFFFE);  // lone sensor at the low end
    send_word(16'h7FFF);  // lone sensor at the high end

    // Zero sensor count: nothing is looked at.
    wait_drained();
    write_config(16'd0, 16'd1, 16'h8000, 16'h7FFF);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'hAAAA);

    // Count above the bar width saturates; active high; coordinate extremes.
    wait_drained();
    write_config(16'd31, 16'd1, 16'h7FFF, 16'h8000);
    send_word(16'h5555);
    send_word(16'hFFFF);
    send_word(16'h8001);
    send_word(16'h0000);

    // Single sensor in use.
    wait_drained();
    write_config(16'd1, 16'd1, 16'h0000, 16'hFFFF);
    send_word(16'h0001);
    send_word(16'hFFFE);

    // Just above the bar width, active low.
    wait_drained();
    write_config(16'd17, 16'd0, 16'hFFFF, 16'h0001);
    send_word(16'h0000);
    send_word(16'hAAAA);

    // Random phases; one runs without gaps and with the long output hold-off,
    // two more without gaps at all, the rest with random idling on both sides.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      random_config();
      idle_on  = (p % 3 != 1);
      if (p == 1) hold_req = 1'b1;
      repeat (WORDS_PER_PHASE) send_word(random_word());
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sbrm_pkg.sv
rtl/core/sbrm_front.sv
rtl/core/sbrm_queue.sv
rtl/core/sbrm_back.sv
rtl/core/sensor_bar_run_midpoints.sv
verif/sensor_bar_run_midpoints_tb.sv
